// ===== rtl/rqit_pkg.sv =====
// Shared codes for the ray against quad intersection tester.
// Holds miss reason codes, configuration register indexes and the reach width and reset value; no dependencies.
`timescale 1ns / 1ps
package rqit_pkg;

   typedef enum logic [1:0] {
      REASON_HIT     = 2'd0,
      REASON_REACH   = 2'd1,
      REASON_PLANE   = 2'd2,
      REASON_OUTSIDE = 2'd3
   } reason_type;

   typedef enum logic [2:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5,
      REG_REACH    = 3'd6
   } reg_index_type;

   localparam int REACH_WIDTH = 8;
   localparam int REACH_RESET = 5;

endpackage

// ===== rtl/ray_quad_intersection_test_top.sv =====
// Top level of the ray against quad intersection tester: ten-stage pipeline,
// with rqit_mul, a pipelined signed multiplier built from 32x32 pieces.
// Depends on rqit_pkg for reason codes and register indexes.
// Throughput: one quad per cycle; the pipeline stalls as a whole only while the
// response register holds a beat that is not taken.
// Reset (synchronous, active high) clears all valid bits and loads origin 0,
// direction (0,0,1.0) and reach 5.
`timescale 1ns / 1ps
module ray_quad_intersection_test_top #(
   parameter int COORD_WIDTH = 24,
   parameter int FRAC_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // va_x, va_y, va_z, vb_x, vb_y, vb_z, vc_x, vc_y, vc_z, vd_x, vd_y, vd_z
   input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // hit, miss_reason[1:0]
   output logic [7:0]             rsp_tdata,
   input  logic                   csr_we,
   input  logic [2:0]             csr_addr,
   input  logic [COORD_WIDTH-1:0] csr_wdata
);

   localparam int W    = COORD_WIDTH;
   localparam int DW   = W + 1;
   localparam int NW   = 2 * DW + 1;
   localparam int GW   = DW + W + 1;
   localparam int SQW  = 2 * DW + 2;
   localparam int DENW = NW + W + 2;
   localparam int NUMW = NW + DW + 2;
   localparam int AW   = 2 * NW + 2;
   localparam int BW   = GW + NW + 2;
   localparam int PW   = DENW + AW;
   localparam int QW   = NUMW + BW;
   localparam int SW   = ((PW > QW) ? PW : QW) + 1;
   localparam int RSW  = rqit_pkg::REACH_WIDTH + FRAC_BITS;

   // configuration
   logic signed [W-1:0] org_ff [3];
   logic signed [W-1:0] dir_ff [3];
   logic [rqit_pkg::REACH_WIDTH-1:0] reach_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            org_ff[i] <= '0;
            dir_ff[i] <= (i == 2) ? (W'(1) << FRAC_BITS) : '0;
         end
         reach_ff  <= rqit_pkg::REACH_WIDTH'(rqit_pkg::REACH_RESET);
      end else if (csr_we) begin
         case (csr_addr)
            rqit_pkg::REG_ORIGIN_X: org_ff[0] <= csr_wdata;
            rqit_pkg::REG_ORIGIN_Y: org_ff[1] <= csr_wdata;
            rqit_pkg::REG_ORIGIN_Z: org_ff[2] <= csr_wdata;
            rqit_pkg::REG_DIR_X:    dir_ff[0] <= csr_wdata;
            rqit_pkg::REG_DIR_Y:    dir_ff[1] <= csr_wdata;
            rqit_pkg::REG_DIR_Z:    dir_ff[2] <= csr_wdata;
            rqit_pkg::REG_REACH:    reach_ff <= csr_wdata[rqit_pkg::REACH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   logic adv;
   logic [8:0] v_ff;
   logic out_valid_ff;
   logic [2:0] out_data_ff;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_data_ff};

   genvar gi, gk;

   // stage 1: edges and origin offsets
   logic signed [W-1:0]  vert [4][3];
   logic signed [DW-1:0] e_in [4][3], e_ff [4][3];
   logic signed [DW-1:0] ov_in [4][3], ov_ff [4][3];
   logic signed [DW-1:0] ac_in [3], ac_ff [3];

   always_comb begin
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 3; i++)
            vert[k][i] = $signed(req_tdata[(3*k+i)*W +: W]);
      for (int k = 0; k < 4; k++)
         for (int i = 0; i < 3; i++) begin
            e_in[k][i]  = DW'(vert[(k+1)%4][i]) - DW'(vert[k][i]);
            ov_in[k][i] = DW'(org_ff[i]) - DW'(vert[k][i]);
         end
      for (int i = 0; i < 3; i++)
         ac_in[i] = DW'(vert[2][i]) - DW'(vert[0][i]);
   end

   // stage 2: normal, edge cross products, reach
   logic signed [NW-1:0]  n_in [3], n_ff [3];
   logic signed [NW-1:0]  c_in [4][3], c_ff [4][3];
   logic signed [GW-1:0]  g_in [4][3], g_ff [4][3];
   logic signed [DW-1:0]  ov0_ff [3];
   logic signed [SQW-1:0] dist_sq [4];
   logic [2*RSW-1:0]      reach2;
   logic [RSW-1:0]        reach_s;
   logic                  near_in;
   logic [7:0]            near_sr_ff;

   always_comb begin
      reach_s = RSW'(reach_ff) << FRAC_BITS;
      reach2  = (2*RSW)'(reach_s) * (2*RSW)'(reach_s);
      near_in = 1'b0;
      for (int i = 0; i < 3; i++)
         n_in[i] = NW'(e_ff[0][(i+1)%3]) * NW'(ac_ff[(i+2)%3])
                 - NW'(e_ff[0][(i+2)%3]) * NW'(ac_ff[(i+1)%3]);
      for (int k = 0; k < 4; k++) begin
         for (int i = 0; i < 3; i++) begin
            c_in[k][i] = NW'(e_ff[k][(i+1)%3]) * NW'(ov_ff[k][(i+2)%3])
                       - NW'(e_ff[k][(i+2)%3]) * NW'(ov_ff[k][(i+1)%3]);
            g_in[k][i] = GW'(e_ff[k][(i+1)%3]) * GW'(dir_ff[(i+2)%3])
                       - GW'(e_ff[k][(i+2)%3]) * GW'(dir_ff[(i+1)%3]);
         end
         dist_sq[k] = SQW'(ov_ff[k][0]) * SQW'(ov_ff[k][0])
                    + SQW'(ov_ff[k][1]) * SQW'(ov_ff[k][1])
                    + SQW'(ov_ff[k][2]) * SQW'(ov_ff[k][2]);
         if ($unsigned(dist_sq[k]) <= reach2) near_in = 1'b1;
      end
   end

   // stages 3 to 5: plane dot product and edge term products
   logic signed [NW+W-1:0]  dp [3];
   logic signed [NW+DW-1:0] np [3];
   logic signed [2*NW-1:0]  ap [4][3];
   logic signed [GW+NW-1:0] bp [4][3];

   for (gi = 0; gi < 3; gi++) begin : g_plane
      rqit_mul #(.A_WIDTH(NW), .B_WIDTH(W)) u_den (
         .clock(clock), .en(adv), .a(n_ff[gi]), .b(dir_ff[gi]), .prod(dp[gi]));
      rqit_mul #(.A_WIDTH(NW), .B_WIDTH(DW)) u_num (
         .clock(clock), .en(adv), .a(n_ff[gi]), .b(ov0_ff[gi]), .prod(np[gi]));
      for (gk = 0; gk < 4; gk++) begin : g_edge
         rqit_mul #(.A_WIDTH(NW), .B_WIDTH(NW)) u_a (
            .clock(clock), .en(adv), .a(c_ff[gk][gi]), .b(n_ff[gi]), .prod(ap[gk][gi]));
         rqit_mul #(.A_WIDTH(GW), .B_WIDTH(NW)) u_b (
            .clock(clock), .en(adv), .a(g_ff[gk][gi]), .b(n_ff[gi]), .prod(bp[gk][gi]));
      end
   end

   // stage 6: sum the dot products
   logic signed [DENW-1:0] den_in, den_ff;
   logic signed [NUMW-1:0] num_in, num_ff;
   logic signed [AW-1:0]   a_in [4], a_ff [4];
   logic signed [BW-1:0]   b_in [4], b_ff [4];

   always_comb begin
      den_in = '0;
      num_in = '0;
      for (int i = 0; i < 3; i++) begin
         den_in = den_in + DENW'(dp[i]);
         num_in = num_in - NUMW'(np[i]);
      end
      for (int k = 0; k < 4; k++) begin
         a_in[k] = '0;
         b_in[k] = '0;
         for (int i = 0; i < 3; i++) begin
            a_in[k] = a_in[k] + AW'(ap[k][i]);
            b_in[k] = b_in[k] + BW'(bp[k][i]);
         end
      end
   end

   // stages 7 to 9: scale edge terms by den and num
   logic signed [PW-1:0] pm [4];
   logic signed [QW-1:0] qm [4];
   logic plane_bad_in;
   logic [2:0] plane_bad_sr_ff, den_neg_sr_ff;

   for (gk = 0; gk < 4; gk++) begin : g_scale
      rqit_mul #(.A_WIDTH(DENW), .B_WIDTH(AW)) u_p (
         .clock(clock), .en(adv), .a(den_ff), .b(a_ff[gk]), .prod(pm[gk]));
      rqit_mul #(.A_WIDTH(NUMW), .B_WIDTH(BW)) u_q (
         .clock(clock), .en(adv), .a(num_ff), .b(b_ff[gk]), .prod(qm[gk]));
   end

   always_comb begin
      plane_bad_in = (den_ff == '0)
                  || ((num_ff != '0) && (num_ff[NUMW-1] != den_ff[DENW-1]));
   end

   // stage 10: edge signs and reason
   logic signed [SW-1:0] s [4];
   logic edge_fail;
   logic [1:0] reason;

   always_comb begin
      edge_fail = 1'b0;
      for (int k = 0; k < 4; k++) begin
         s[k] = SW'(pm[k]) + SW'(qm[k]);
         if ((s[k] != '0) && (s[k][SW-1] != den_neg_sr_ff[2])) edge_fail = 1'b1;
      end
      if (!near_sr_ff[7])          reason = rqit_pkg::REASON_REACH;
      else if (plane_bad_sr_ff[2]) reason = rqit_pkg::REASON_PLANE;
      else if (edge_fail)          reason = rqit_pkg::REASON_OUTSIDE;
      else                         reason = rqit_pkg::REASON_HIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[7:0], req_tvalid};
         out_valid_ff <= v_ff[8];
      end
   end

   // payload: advance with the pipeline, no reset
   always_ff @(posedge clock) begin
      if (adv) begin
         e_ff  <= e_in;
         ov_ff <= ov_in;
         ac_ff <= ac_in;
         n_ff     <= n_in;
         c_ff     <= c_in;
         g_ff     <= g_in;
         ov0_ff   <= ov_ff[0];
         near_sr_ff <= {near_sr_ff[6:0], near_in};
         den_ff   <= den_in;
         num_ff   <= num_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         plane_bad_sr_ff <= {plane_bad_sr_ff[1:0], plane_bad_in};
         den_neg_sr_ff   <= {den_neg_sr_ff[1:0], den_ff[DENW-1]};
         out_data_ff  <= {reason, reason == rqit_pkg::REASON_HIT};
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");
   a_hit_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == (rsp_tdata[2:1] == rqit_pkg::REASON_HIT)))
      else $error("hit flag disagrees with miss reason");
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("request side stalled without a held response");

endmodule

// Signed multiplier in three register stages: 32x32 partial products,
// row sums, final sum. Every stage holds while en is low.
module rqit_mul #(
   parameter int A_WIDTH = 32,
   parameter int B_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [A_WIDTH-1:0]         a,
   input  logic signed [B_WIDTH-1:0]         b,
   output logic signed [A_WIDTH+B_WIDTH-1:0] prod
);

   localparam int L  = 31;
   localparam int NA = (A_WIDTH + L - 1) / L;
   localparam int NB = (B_WIDTH + L - 1) / L;
   localparam int PW = A_WIDTH + B_WIDTH;

   logic signed [NA*L-1:0] ax;
   logic signed [NB*L-1:0] bx;
   logic signed [L:0]      al [NA];
   logic signed [L:0]      bl [NB];
   logic signed [2*L+1:0]  pp_ff [NA][NB];
   logic signed [PW-1:0]   row_in [NA], row_ff [NA];
   logic signed [PW-1:0]   prod_in, prod_ff;

   // low limbs are unsigned, the top limb carries the sign
   always_comb begin
      ax = (NA*L)'(a);
      bx = (NB*L)'(b);
      for (int i = 0; i < NA; i++)
         al[i] = {(i == NA - 1) ? ax[NA*L-1] : 1'b0, ax[i*L +: L]};
      for (int j = 0; j < NB; j++)
         bl[j] = {(j == NB - 1) ? bx[NB*L-1] : 1'b0, bx[j*L +: L]};
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++)
            row_in[i] = row_in[i] + (PW'(pp_ff[i][j]) <<< (L * j));
      end
      prod_in = '0;
      for (int i = 0; i < NA; i++)
         prod_in = prod_in + (row_ff[i] <<< (L * i));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NA; i++)
            for (int j = 0; j < NB; j++)
               pp_ff[i][j] <= al[i] * bl[j];
         row_ff  <= row_in;
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule
